>>> hdl/sls_pkg.sv
`default_nettype none

package sls_pkg;

   // Request kinds
   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_EDIT   = 3'd2;
   localparam logic [2:0] OP_DELETE = 3'd3;
   localparam logic [2:0] OP_GET    = 3'd4;
   localparam logic [2:0] OP_FIND   = 3'd5;

   // Result status codes
   localparam logic [2:0] STS_OK    = 3'd0;
   localparam logic [2:0] STS_FULL  = 3'd1;
   localparam logic [2:0] STS_RANGE = 3'd2;
   localparam logic [2:0] STS_EMPTY = 3'd3;
   localparam logic [2:0] STS_MISS  = 3'd4;

   // Capacity register value after reset
   localparam logic [6:0] CAP_RESET = 7'd64;

   // Cell update commands, broadcast to the whole row
   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_WRITE = 2'd1;
   localparam logic [1:0] CELL_UP    = 2'd2;
   localparam logic [1:0] CELL_DOWN  = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_res_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] read_value;
      logic [5:0]         found_position;
      logic [6:0]         entry_count;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

endpackage

`default_nettype wire

>>> hdl/shifting_list_store.sv
// Ordered list of signed 32-bit values held in a row of cells, one entry per
// cell. Requests arrive on the req_ channel (valid/ready): append, insert,
// edit, delete, get and find. Each accepted transaction yields exactly one
// result on the rsp_ channel (valid/ready) with status, read value, found
// index, entry count and empty/full flags.
// The csr_ channel writes the capacity limit; write it only while idle.
// Append, insert, edit, delete and get complete in the accept cycle: every
// cell loads from itself, its neighbor or the request at the accept edge, and
// the result is registered into the output queue; a new request can be taken
// every cycle while req_ready is high. Find first latches all cell compares
// in the load state, then scans the match bits eight entries per cycle up to
// the group of the first match or the end of the list (at least one group).
// A find result is registered into the output queue when the scan ends.
// Results go through a two-entry output queue; when the receiver stalls,
// the block takes one more transaction and then drops req_ready.
// Synchronous reset empties the list, sets capacity to 64 and drops the
// queue; the entry storage itself is not cleared.
`default_nettype none

module shifting_list_store #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [6:0]         csr_capacity_in_use,
   // request
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_type,
   input  wire logic [5:0]         req_position,
   input  wire logic signed [31:0] req_item_value,
   // result
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_read_value,
   output logic [5:0]              rsp_found_position,
   output logic [6:0]              rsp_entry_count,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full
);
   import sls_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = (CW > 6) ? CW : 6;
   localparam int EW = (CW > 7) ? CW : 7;
   localparam int AW = $clog2(MAX_ENTRIES);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [6:0]    cap_ff, cap_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   key_ff, key_in;
   rsp_type       out_ff, out_in, skid_ff, skid_in;
   logic          out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic          accept;
   logic          push;
   logic          pop;
   rsp_type       push_data;
   rsp_type       now_rsp;
   rsp_type       find_rsp;

   logic [EW-1:0] cap_eff;
   logic [EW-1:0] cap_w;
   logic [EW-1:0] count_e;
   logic [EW-1:0] count_next_e;
   logic [IW-1:0] pos_w;
   logic          full;
   logic          in_range;
   logic          empty;
   logic [AW-1:0] rd_idx;

   logic [CW-1:0] count_next;
   logic [2:0]    status;
   logic [31:0]   rd;
   cell_cmd_type  op_cmd;
   cell_cmd_type  cmd;
   logic [IW-1:0] target;

   logic [31:0]            entry_vec [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] match_vec;
   scan_res_type           scan_res;
   logic [5:0]             scan_pos;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && !skid_valid_ff;

   // Effective capacity: zero acts as one, clamp to the row length
   assign cap_w = EW'(cap_ff);
   always_comb begin
      if (cap_ff == 7'd0) cap_eff = EW'(1);
      else if (cap_w > EW'(MAX_ENTRIES)) cap_eff = EW'(MAX_ENTRIES);
      else cap_eff = cap_w;
   end

   assign count_e  = EW'(count_ff);
   assign pos_w    = IW'(req_position);
   assign full     = count_e >= cap_eff;
   assign in_range = pos_w < IW'(count_ff);
   assign empty    = (count_ff == '0);
   assign rd_idx   = pos_w[AW-1:0];

   // Request decode: status, count update and row command
   always_comb begin
      status       = STS_OK;
      rd           = 32'd0;
      count_next   = count_ff;
      op_cmd.op    = CELL_HOLD;
      op_cmd.value = req_item_value;
      target       = pos_w;
      case (req_type)
         OP_APPEND: begin
            if (full) begin
               status = STS_FULL;
            end else begin
               op_cmd.op  = CELL_WRITE;
               target     = IW'(count_ff);
               count_next = count_ff + CW'(1);
            end
         end
         OP_INSERT: begin
            if (full) begin
               status = STS_FULL;
            end else if (!in_range) begin
               status = STS_RANGE;
            end else begin
               op_cmd.op  = CELL_UP;
               count_next = count_ff + CW'(1);
            end
         end
         OP_EDIT: begin
            if (!in_range) status = STS_RANGE;
            else op_cmd.op = CELL_WRITE;
         end
         OP_DELETE: begin
            if (empty) begin
               status = STS_EMPTY;
            end else if (!in_range) begin
               status = STS_RANGE;
            end else begin
               op_cmd.op  = CELL_DOWN;
               count_next = count_ff - CW'(1);
            end
         end
         OP_GET: begin
            if (empty) status = STS_EMPTY;
            else if (!in_range) status = STS_RANGE;
            else rd = entry_vec[rd_idx];
         end
         default: begin
            status = STS_OK;
         end
      endcase
   end

   assign cmd.op    = accept ? op_cmd.op : CELL_HOLD;
   assign cmd.value = op_cmd.value;

   // Row of entry cells
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [31:0] left_v;
      logic [31:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = cmd.value;
      end else begin : g_left
         assign left_v = entry_vec[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign right_v = entry_vec[i];
      end else begin : g_right
         assign right_v = entry_vec[i+1];
      end
      sls_cell #(
         .IDX (i),
         .IW  (IW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .target      (target),
         .left_value  (left_v),
         .right_value (right_v),
         .key         (key_ff),
         .entry       (entry_vec[i]),
         .match       (match_vec[i])
      );
   end

   // Match scan for find
   sls_scan #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .clear     (state_ff == S_LOAD),
      .active    (state_ff == S_SCAN),
      .match_vec (match_vec),
      .count     (count_ff),
      .res       (scan_res),
      .found_pos (scan_pos)
   );

   // Result of a request completed at accept
   assign count_next_e = EW'(count_next);
   always_comb begin
      now_rsp.status         = status;
      now_rsp.read_value     = rd;
      now_rsp.found_position = 6'd0;
      now_rsp.entry_count    = count_next_e[6:0];
      now_rsp.is_empty       = (count_next == '0);
      now_rsp.is_full        = count_next_e >= cap_eff;
   end

   // Result of a find
   always_comb begin
      find_rsp.status         = scan_res.found ? STS_OK : STS_MISS;
      find_rsp.read_value     = 32'sd0;
      find_rsp.found_position = scan_res.found ? scan_pos : 6'd0;
      find_rsp.entry_count    = count_e[6:0];
      find_rsp.is_empty       = empty;
      find_rsp.is_full        = full;
   end

   assign push      = (accept && (req_type != OP_FIND)) ||
                      ((state_ff == S_SCAN) && scan_res.done);
   assign push_data = (state_ff == S_SCAN) ? find_rsp : now_rsp;
   assign pop       = out_valid_ff && rsp_ready;

   // Two-entry output queue
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // Control sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_type == OP_FIND)) state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_res.done) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cap_in   = (csr_valid && csr_ready) ? csr_capacity_in_use : cap_ff;
   assign count_in = accept ? count_next : count_ff;
   assign key_in   = (accept && (req_type == OP_FIND)) ? req_item_value : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cap_ff        <= CAP_RESET;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_read_value     = out_ff.read_value;
   assign rsp_found_position = out_ff.found_position;
   assign rsp_entry_count    = out_ff.entry_count;
   assign rsp_is_empty       = out_ff.is_empty;
   assign rsp_is_full        = out_ff.is_full;

   // Checks
   a_skid_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result pushed while skid entry occupied");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond row length");

   a_find_loads: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == OP_FIND)) |=> (state_ff == S_LOAD))
      else $error("find did not start the compare cycle");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + CW'(1) ||
                         count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count moved by more than one");

endmodule

`default_nettype wire

>>> hdl/sls_cell.sv
`default_nettype none

module sls_cell #(
   parameter int IDX = 0,
   parameter int IW  = 7
) (
   input  wire logic                 clock,
   input  wire sls_pkg::cell_cmd_type cmd,
   input  wire logic [IW-1:0]        target,
   input  wire logic [31:0]          left_value,
   input  wire logic [31:0]          right_value,
   input  wire logic [31:0]          key,
   output logic [31:0]               entry,
   output logic                      match
);
   import sls_pkg::*;

   localparam logic [IW-1:0] IDXW = IW'(IDX);

   logic [31:0] entry_ff, entry_in;
   logic        match_ff, match_in;

   // Next entry: keep, take the broadcast value, or take a neighbor's entry
   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_WRITE: begin
            if (IDXW == target) entry_in = cmd.value;
         end
         CELL_UP: begin
            if (IDXW == target) entry_in = cmd.value;
            else if (IDXW > target) entry_in = left_value;
         end
         CELL_DOWN: begin
            if (IDXW >= target) entry_in = right_value;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Local compare against the search key
   assign match_in = (entry_ff == key);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

>>> hdl/sls_scan.sv
`default_nettype none

module sls_scan #(
   parameter int MAX_ENTRIES = 64,
   localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   clear,
   input  wire logic                   active,
   input  wire logic [MAX_ENTRIES-1:0] match_vec,
   input  wire logic [CW-1:0]          count,
   output sls_pkg::scan_res_type       res,
   output logic [5:0]                  found_pos
);
   import sls_pkg::*;

   localparam int G    = (MAX_ENTRIES + 7) / 8;
   localparam int GW   = (G > 1) ? $clog2(G) : 1;
   localparam int SW   = GW + 3;
   localparam int KW   = (SW + 1 > CW) ? SW + 1 : CW;
   localparam int PADW = G * 8;

   logic [GW-1:0]   grp_ff, grp_in;
   logic [PADW-1:0] pad;
   logic [7:0]      grp_bits;
   logic [7:0]      live;
   logic [7:0]      hits;
   logic [2:0]      off;
   logic            last;
   logic [KW-1:0]   cnt_k;
   logic [SW+5:0]   idx_wide;

   assign pad      = PADW'(match_vec);
   assign grp_bits = pad[grp_ff*8 +: 8];
   assign cnt_k    = KW'(count);

   // Only entries below the count take part
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         live[j] = KW'({grp_ff, 3'(j)}) < cnt_k;
      end
   end

   assign hits = grp_bits & live;

   // Lowest set bit in the group
   always_comb begin
      off = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (hits[j]) off = 3'(j);
      end
   end

   // This group reaches the end of the list
   assign last = (KW'({grp_ff, 3'b111}) + KW'(1)) >= cnt_k;

   assign res.found = |hits;
   assign res.done  = active && ((|hits) || last);

   assign idx_wide  = (SW + 6)'({grp_ff, off});
   assign found_pos = idx_wide[5:0];

   // Group pointer: restart on clear, step while the scan goes on
   always_comb begin
      grp_in = grp_ff;
      if (clear) grp_in = '0;
      else if (active && !res.done) grp_in = grp_ff + GW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff <= '0;
      end else begin
         grp_ff <= grp_in;
      end
   end

endmodule

`default_nettype wire
